[sv/gmdt_pkg.sv]
`timescale 1ns / 1ps
package gmdt_pkg;
	localparam int unsigned ModeW = 2;
	localparam int unsigned DistW = 7;
	localparam int unsigned CfgW = 7;
	localparam logic [ModeW-1:0] MODE_LOAD = 2'd0;
	localparam logic [ModeW-1:0] MODE_RUN = 2'd1;
	localparam logic [ModeW-1:0] MODE_READ = 2'd2;
	localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
	localparam logic [0:0] CFG_ROWS = 1'b0;
	localparam logic [0:0] CFG_COLS = 1'b1;
	localparam logic [DistW-1:0] DIST_UNREACH = 7'd127;
	localparam logic [DistW-1:0] DIST_MAX = 7'd126;
	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [5:0] row;
		logic [5:0] col;
		logic cell_value;
	} in_beat_t;

	typedef struct packed {
		logic kind;
		logic [DistW-1:0] distance;
		logic no_source;
	} out_beat_t;
endpackage

[sv/gmdt_if.sv]
`timescale 1ns / 1ps
interface gmdt_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/gmdt_engine.sv]
`timescale 1ns / 1ps
// Search sequencer: one memory access per cycle through a shared compare and update step.
module gmdt_engine #(
	parameter int unsigned MAX_ROWS = 64,
	parameter int unsigned MAX_COLS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [gmdt_pkg::CfgW-1:0] cfg_data,
	gmdt_if.sink in_ch,
	gmdt_if.source out_ch
);
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned AW = RW + CW;
	localparam int unsigned CELLS = 1 << AW;
	localparam int unsigned QW = AW + 1;
	localparam int unsigned DW = gmdt_pkg::DistW;
	localparam int unsigned CFW = gmdt_pkg::CfgW;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001, ST_SEED = 7'b0000010, ST_POP = 7'b0000100,
		ST_CUR = 7'b0001000, ST_NREQ = 7'b0010000, ST_NCHK = 7'b0100000,
		ST_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic cell_mem [CELLS];
	logic [DW-1:0] dist_mem [CELLS];
	logic [AW-1:0] queue_mem [CELLS];
	logic [CFW-1:0] rows_q, cols_q;
	logic [QW-1:0] head_q, tail_q;
	logic [RW-1:0] sr_q;
	logic [CW-1:0] sc_q;
	logic seed_wait_q;
	logic [RW-1:0] cr_q;
	logic [CW-1:0] cc_q;
	logic [DW-1:0] nd_q;
	logic [1:0] dir_q;
	logic [AW-1:0] nix_q;
	logic cell_rd_q;
	logic [DW-1:0] dist_rd_q;
	logic [AW-1:0] q_rd_q;
	logic out_valid_q;
	gmdt_pkg::out_beat_t out_q;
	logic none_q;
	logic rd_pend_q, rd_out_q;

	function automatic logic [CFW-1:0] clamp(input logic [CFW-1:0] v,
			input int unsigned m);
		logic [CFW-1:0] r;
		r = v;
		if (v == '0) r = 7'd1;
		else if (int'(v) > m) r = CFW'(m);
		return r;
	endfunction

	// Neighbour coordinates for the current direction (up, right, down, left).
	logic [RW:0] nr;
	logic [CW:0] nc;
	logic n_ok;
	always_comb begin
		nr = {1'b0, cr_q};
		nc = {1'b0, cc_q};
		case (dir_q)
			2'd0: nr = {1'b0, cr_q} - 1'b1;
			2'd1: nc = {1'b0, cc_q} + 1'b1;
			2'd2: nr = {1'b0, cr_q} + 1'b1;
			default: nc = {1'b0, cc_q} - 1'b1;
		endcase
		n_ok = !nr[RW] && !nc[CW] && (CFW'(nr) < rows_q) && (CFW'(nc) < cols_q);
	end

	wire in_fire = in_ch.valid && in_ch.ready;
	wire [AW-1:0] in_ix = {RW'(in_ch.payload.row), CW'(in_ch.payload.col)};
	wire in_inside = (int'(in_ch.payload.row) < MAX_ROWS) && (int'(in_ch.payload.col) < MAX_COLS);
	wire [AW-1:0] seed_ix = {sr_q, sc_q};
	wire [AW-1:0] n_ix = {nr[RW-1:0], nc[CW-1:0]};
	wire q_full = (tail_q == QW'(CELLS));

	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready) && !rd_pend_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	// Memories: cell bits, distances and the visit queue.
	always_ff @(posedge clk) begin
		cell_rd_q <= cell_mem[seed_ix];
		q_rd_q <= queue_mem[head_q[AW-1:0]];
		case (state_q)
			ST_CUR: dist_rd_q <= dist_mem[q_rd_q];
			ST_NREQ: dist_rd_q <= dist_mem[n_ix];
			default: dist_rd_q <= dist_mem[in_ix];
		endcase
		if (in_fire && in_ch.payload.mode == gmdt_pkg::MODE_LOAD && in_inside)
			cell_mem[in_ix] <= in_ch.payload.cell_value;
		if (state_q == ST_SEED && !seed_wait_q) begin
			dist_mem[seed_ix] <= cell_rd_q ? gmdt_pkg::DIST_UNREACH : '0;
			if (!cell_rd_q && !q_full) queue_mem[tail_q[AW-1:0]] <= seed_ix;
		end
		if (state_q == ST_NCHK && dist_rd_q > nd_q) begin
			dist_mem[nix_q] <= nd_q;
			if (!q_full) queue_mem[tail_q[AW-1:0]] <= nix_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= clamp(7'd64, MAX_ROWS);
			cols_q <= clamp(7'd64, MAX_COLS);
			head_q <= '0;
			tail_q <= '0;
			sr_q <= '0;
			sc_q <= '0;
			seed_wait_q <= 1'b0;
			cr_q <= '0;
			cc_q <= '0;
			nd_q <= '0;
			dir_q <= '0;
			nix_q <= '0;
			none_q <= 1'b0;
			out_q <= '0;
			out_valid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_out_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gmdt_pkg::CFG_ROWS) rows_q <= clamp(cfg_data, MAX_ROWS);
				else cols_q <= clamp(cfg_data, MAX_COLS);
			end
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
				out_q <= '{gmdt_pkg::KIND_READ, rd_out_q ? dist_rd_q : gmdt_pkg::DIST_UNREACH,
					1'b0};
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.payload.mode)
							gmdt_pkg::MODE_RUN: begin
								head_q <= '0;
								tail_q <= '0;
								sr_q <= '0;
								sc_q <= '0;
								seed_wait_q <= 1'b1;
								state_q <= ST_SEED;
							end
							gmdt_pkg::MODE_READ: begin
								rd_pend_q <= 1'b1;
								rd_out_q <= ({1'b0, in_ch.payload.row} < rows_q) &&
									({1'b0, in_ch.payload.col} < cols_q);
							end
							default: ;
						endcase
					end
				end
				ST_SEED: begin
					// Each cell is first looked up and then updated.
					if (seed_wait_q) begin
						seed_wait_q <= 1'b0;
					end else begin
						seed_wait_q <= 1'b1;
						if (!cell_rd_q && !q_full) tail_q <= tail_q + 1'b1;
						if (CFW'(sc_q) == cols_q - 1'b1) begin
							sc_q <= '0;
							if (CFW'(sr_q) == rows_q - 1'b1) begin
								state_q <= ST_POP;
								none_q <= (tail_q == '0) && cell_rd_q;
							end else begin
								sr_q <= sr_q + 1'b1;
							end
						end else begin
							sc_q <= sc_q + 1'b1;
						end
					end
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						state_q <= ST_OUT;
					end else begin
						head_q <= head_q + 1'b1;
						state_q <= ST_CUR;
					end
				end
				ST_CUR: begin
					{cr_q, cc_q} <= q_rd_q;
					dir_q <= '0;
					state_q <= ST_NREQ;
				end
				ST_NREQ: begin
					if (dir_q == 2'd0)
						nd_q <= (dist_rd_q >= gmdt_pkg::DIST_MAX) ? gmdt_pkg::DIST_MAX
							: dist_rd_q + 1'b1;
					nix_q <= n_ix;
					if (n_ok) state_q <= ST_NCHK;
					else if (dir_q == 2'd3) state_q <= ST_POP;
					else dir_q <= dir_q + 1'b1;
				end
				ST_NCHK: begin
					if (dist_rd_q > nd_q && !q_full) tail_q <= tail_q + 1'b1;
					if (dir_q == 2'd3) begin
						state_q <= ST_POP;
					end else begin
						dir_q <= dir_q + 1'b1;
						state_q <= ST_NREQ;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_q <= '{gmdt_pkg::KIND_DONE, '0, none_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[sv/grid_manhattan_distance_transform_core.sv]
`timescale 1ns / 1ps
// Load beats: one per cycle while the result slot is free or draining and no read is
// pending. A read beat holds off further beats until its registered result is placed.
// Search beat: every cell is seeded, then each queue pop checks the in-grid
// neighbours, and a done beat finishes the search; ready is low throughout.
// Asynchronous active-low reset clears control and restores 64 rows and 64 columns
// (clamped to MAX_ROWS and MAX_COLS); the grid and distance memories are not cleared.
module grid_manhattan_distance_transform_core #(
	parameter int unsigned MAX_ROWS = 64,
	parameter int unsigned MAX_COLS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [gmdt_pkg::CfgW-1:0] cfg_data,
	gmdt_if.sink in_ch,
	gmdt_if.source out_ch
);
	gmdt_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_engine (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_ch, .out_ch
	);
endmodule

[sv/gmdt_checker.sv]
`timescale 1ns / 1ps
module gmdt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input gmdt_pkg::out_beat_t out_payload
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("out hold");
	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.kind == gmdt_pkg::KIND_READ |-> !out_payload.no_source)
		else $error("read no_source");
	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.kind == gmdt_pkg::KIND_DONE |-> out_payload.distance == '0)
		else $error("done distance");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready || !out_valid) else $error("busy");
	// An input beat is taken only when the result slot is free or draining.
	a_accept_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_ready) else $error("accept slot");
endmodule

bind grid_manhattan_distance_transform_core gmdt_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
